// ----- rtl/core/fpcv_pkg.sv -----
`timescale 1ns / 1ps
package fpcv_pkg;
  localparam int TRIG_ITERATIONS_DEF = 16;
  localparam int POS_FRAC_BITS_DEF   = 16;
  localparam int ATAN_ENTRIES        = 24;
  localparam logic [1:0] REQ_MOVE = 2'd0;
  localparam logic [1:0] REQ_LOOK = 2'd1;
  localparam logic [1:0] REQ_SETP = 2'd2;
  localparam logic [1:0] REQ_VIEW = 2'd3;
  localparam logic [2:0] DIR_FWD   = 3'd0;
  localparam logic [2:0] DIR_BACK  = 3'd1;
  localparam logic [2:0] DIR_LEFT  = 3'd2;
  localparam logic [2:0] DIR_RIGHT = 3'd3;
  localparam logic CFG_SPEED = 1'b0;
  localparam logic CFG_SENS  = 1'b1;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
  localparam logic signed [33:0] DEG80  = 34'sd5242880;
  localparam logic signed [33:0] DEG90  = 34'sd5898240;
  localparam logic signed [33:0] DEG180 = 34'sd11796480;
  localparam logic signed [33:0] DEG360 = 34'sd23592960;
  localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [15:0]        frame_time;
    logic [2:0]         move_dir;
    logic signed [15:0] offset_horiz;
    logic signed [15:0] offset_vert;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] col0;
    logic signed [31:0] col1;
    logic signed [31:0] col2;
    logic signed [31:0] col3;
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
    logic               last_row;
  } out_item_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] angle;
  } trig_req_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] sin_v;
    logic signed [15:0] cos_v;
  } trig_rsp_t;

  function automatic logic signed [31:0] atan_q16(input logic [4:0] i);
    case (i)
      5'd0: return 32'sd2949120;  5'd1: return 32'sd1740967;
      5'd2: return 32'sd919879;   5'd3: return 32'sd466945;
      5'd4: return 32'sd234379;   5'd5: return 32'sd117304;
      5'd6: return 32'sd58666;    5'd7: return 32'sd29335;
      5'd8: return 32'sd14668;    5'd9: return 32'sd7334;
      5'd10: return 32'sd3667;    5'd11: return 32'sd1833;
      5'd12: return 32'sd917;     5'd13: return 32'sd458;
      5'd14: return 32'sd229;     5'd15: return 32'sd115;
      5'd16: return 32'sd57;      5'd17: return 32'sd29;
      5'd18: return 32'sd14;      5'd19: return 32'sd7;
      5'd20: return 32'sd4;       5'd21: return 32'sd2;
      5'd22: return 32'sd1;
      default: return 32'sd0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -66'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction
endpackage

// ----- rtl/core/fpcv_stream_if.sv -----
`timescale 1ns / 1ps
interface fpcv_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/first_person_camera_view_core.sv -----
`timescale 1ns / 1ps
// Set position and unused move codes complete on accept; look and move each run
//   through their own multiply steps before the next accept.
// A view runs the CORDIC on yaw, then on pitch, then 4 vector multiply steps and
//   the dot-product steps (three products and a fold per row) before its first row.
// One item at a time, taken only in idle; the CORDIC and 34x18 multiplier are shared.
// Reset (rst_n sync low): pitch 0, yaw 90 deg, position 0, front and right vectors default.
module first_person_camera_view_core #(
  parameter int TRIG_ITERATIONS = fpcv_pkg::TRIG_ITERATIONS_DEF,
  parameter int POS_FRAC_BITS   = fpcv_pkg::POS_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  fpcv_stream_if.sink   in_ch,
  fpcv_stream_if.source out_ch
);
  import fpcv_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_MOVE = 4'd1, S_LOOK = 4'd2,
                         S_TY = 4'd3, S_TP = 4'd4, S_VEC = 4'd5, S_DOT = 4'd6,
                         S_OUT = 4'd7;
  localparam int MSH = 38 - POS_FRAC_BITS;

  logic [3:0] state_r;
  logic [15:0] speed_r, sens_r;
  logic signed [31:0] pitch_r, yaw_r;
  logic signed [31:0] pos_r [3];
  logic signed [15:0] front_r [3];
  logic signed [15:0] right_r [3];
  logic signed [15:0] up_r [3];
  logic signed [15:0] sy_r, cy_r, sp_r, cp_r;
  logic signed [31:0] trans_r [3];
  logic [2:0] step_r;
  logic [1:0] row_r;
  logic signed [65:0] acc_r;
  in_item_t item_r;
  trig_req_t treq;
  trig_rsp_t trsp;

  fpcv_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .req(treq), .rsp(trsp));

  // Shared multiplier: one signed 34x18 product per cycle.
  logic signed [33:0] ma;
  logic signed [17:0] mb;
  logic signed [51:0] mp;
  logic signed [65:0] rnd;
  assign mp = ma * mb;

  function automatic logic signed [65:0] rsh(input logic signed [65:0] v, input int s);
    return (v + (66'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] to_pos(input logic signed [15:0] v);
    return 32'(rsh(66'(v) <<< POS_FRAC_BITS, 14));
  endfunction

  logic signed [15:0] mv [3];
  logic [1:0] mi;
  // move steps 1..3 handle coordinates 0..2
  assign mi = step_r[1:0] - 2'd1;

  always_comb begin
    ma = '0; mb = '0;
    for (int k = 0; k < 3; k++)
      mv[k] = (item_r.move_dir < 3'd2) ? front_r[k] : right_r[k];
    rnd = '0;
    case (state_r)
      S_MOVE: begin
        if (step_r == 3'd0) begin
          ma = 34'(speed_r); mb = 18'(item_r.frame_time);
        end else begin
          ma = 34'(acc_r); mb = 18'(mv[mi]);
        end
      end
      S_LOOK: begin
        if (step_r == 3'd0) begin
          ma = 34'(sens_r); mb = 18'(item_r.frame_time);
        end else begin
          ma = 34'(acc_r);
          mb = (step_r == 3'd1) ? 18'(item_r.offset_vert) : 18'(item_r.offset_horiz);
        end
      end
      S_VEC: begin
        case (step_r)
          3'd0: begin ma = 34'(cy_r); mb = 18'(cp_r); end
          3'd1: begin ma = 34'(sy_r); mb = 18'(cp_r); end
          3'd2: begin ma = 34'(cy_r); mb = 18'(sp_r); end
          default: begin ma = 34'(sy_r); mb = 18'(sp_r); end
        endcase
      end
      S_DOT: begin
        // step 3 only folds the sum, the product is unused
        if (step_r != 3'd3) begin
          ma = 34'(pos_r[step_r[1:0]]);
          case (row_r)
            2'd0: mb = 18'(right_r[step_r[1:0]]);
            2'd1: mb = 18'(up_r[step_r[1:0]]);
            default: mb = 18'(front_r[step_r[1:0]]);
          endcase
        end
      end
      default: ;
    endcase
    rnd = rsh(66'(mp), 14);
  end

  logic signed [65:0] dlt, lk, pn, yn;
  logic signed [31:0] ps, ys;
  always_comb begin
    dlt = rsh(66'(mp), MSH);
    if (item_r.move_dir == DIR_BACK || item_r.move_dir == DIR_LEFT) dlt = -dlt;
    lk = rsh(66'(mp), 12);
    pn = 66'(pitch_r) + lk;
    yn = 66'(yaw_r) + lk;
    ps = sat32(pn);
    ys = sat32(yn);
    if (34'(ps) > DEG80) ps = 32'(DEG80);
    else if (34'(ps) < -DEG80) ps = 32'(-DEG80);
    if (34'(ys) > DEG360 || 34'(ys) < -DEG360) ys = '0;
  end

  assign treq.start = (state_r == S_TY || state_r == S_TP) && step_r == 3'd0;
  assign treq.angle = (state_r == S_TY) ? yaw_r : pitch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      speed_r <= 16'd1280; sens_r <= 16'd1280;
      pitch_r <= '0; yaw_r <= 32'(DEG90);
      for (int k = 0; k < 3; k++) pos_r[k] <= '0;
      front_r[0] <= '0; front_r[1] <= '0; front_r[2] <= ONE_Q14;
      right_r[0] <= -ONE_Q14; right_r[1] <= '0; right_r[2] <= '0;
      step_r <= '0; row_r <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SPEED) speed_r <= cfg_data;
        else sens_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: if (in_ch.valid) begin
          item_r <= in_ch.data;
          step_r <= '0;
          case (in_ch.data.req_type)
            REQ_MOVE: if (in_ch.data.move_dir <= DIR_RIGHT) state_r <= S_MOVE;
            REQ_LOOK: state_r <= S_LOOK;
            REQ_SETP: begin
              pos_r[0] <= in_ch.data.new_x; pos_r[1] <= in_ch.data.new_y;
              pos_r[2] <= in_ch.data.new_z;
            end
            default: state_r <= S_TY;
          endcase
        end
        S_MOVE: begin
          step_r <= step_r + 3'd1;
          if (step_r == 3'd0) acc_r <= 66'(mp);
          else begin
            pos_r[mi] <= sat32(66'(pos_r[mi]) + dlt);
            if (step_r == 3'd3) state_r <= S_IDLE;
          end
        end
        S_LOOK: begin
          step_r <= step_r + 3'd1;
          if (step_r == 3'd0) acc_r <= 66'(mp);
          else if (step_r == 3'd1) pitch_r <= ps;
          else begin yaw_r <= ys; state_r <= S_IDLE; end
        end
        S_TY, S_TP: begin
          if (trsp.done && step_r != 3'd0) begin
            step_r <= '0;
            if (state_r == S_TY) begin
              sy_r <= trsp.sin_v; cy_r <= trsp.cos_v; state_r <= S_TP;
            end else begin
              sp_r <= trsp.sin_v; cp_r <= trsp.cos_v; state_r <= S_VEC;
            end
          end else begin
            step_r <= 3'd1;
          end
        end
        S_VEC: begin
          case (step_r)
            3'd0: begin front_r[0] <= rnd[15:0]; step_r <= step_r + 3'd1; end
            3'd1: begin front_r[2] <= rnd[15:0]; step_r <= step_r + 3'd1; end
            3'd2: begin up_r[0] <= -rnd[15:0]; step_r <= step_r + 3'd1; end
            default: begin
              up_r[2] <= -rnd[15:0];
              front_r[1] <= sp_r; up_r[1] <= cp_r;
              right_r[0] <= -sy_r; right_r[1] <= '0; right_r[2] <= cy_r;
              state_r <= S_DOT; step_r <= '0; row_r <= '0; acc_r <= '0;
            end
          endcase
        end
        S_DOT: begin
          if (step_r == 3'd3) begin
            step_r <= '0; acc_r <= '0;
            trans_r[row_r] <= (row_r == 2'd2) ? sat32(rsh(acc_r, 14))
                                              : sat32(-66'(sat32(rsh(acc_r, 14))));
            row_r <= (row_r == 2'd2) ? 2'd0 : row_r + 2'd1;
            if (row_r == 2'd2) state_r <= S_OUT;
          end else begin
            acc_r <= acc_r + 66'(mp);
            step_r <= step_r + 3'd1;
          end
        end
        S_OUT: if (out_ch.ready) begin
          row_r <= row_r + 2'd1;
          if (row_r == 2'd3) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);

  always_comb begin
    out_ch.data.row_index = row_r;
    out_ch.data.cam_x = pos_r[0];
    out_ch.data.cam_y = pos_r[1];
    out_ch.data.cam_z = pos_r[2];
    out_ch.data.last_row = (row_r == 2'd3);
    case (row_r)
      2'd0: begin
        out_ch.data.col0 = to_pos(right_r[0]); out_ch.data.col1 = to_pos(right_r[1]);
        out_ch.data.col2 = to_pos(right_r[2]); out_ch.data.col3 = trans_r[0];
      end
      2'd1: begin
        out_ch.data.col0 = to_pos(up_r[0]); out_ch.data.col1 = to_pos(up_r[1]);
        out_ch.data.col2 = to_pos(up_r[2]); out_ch.data.col3 = trans_r[1];
      end
      2'd2: begin
        out_ch.data.col0 = to_pos(-front_r[0]); out_ch.data.col1 = to_pos(-front_r[1]);
        out_ch.data.col2 = to_pos(-front_r[2]); out_ch.data.col3 = trans_r[2];
      end
      default: begin
        out_ch.data.col0 = '0; out_ch.data.col1 = '0; out_ch.data.col2 = '0;
        out_ch.data.col3 = 32'(66'sd1 <<< POS_FRAC_BITS);
      end
    endcase
  end
endmodule

// ----- rtl/core/fpcv_cordic.sv -----
`timescale 1ns / 1ps
module fpcv_cordic #(
  parameter int TRIG_ITERATIONS = fpcv_pkg::TRIG_ITERATIONS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fpcv_pkg::trig_req_t req,
  output fpcv_pkg::trig_rsp_t rsp
);
  import fpcv_pkg::*;
  localparam int N = (TRIG_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : TRIG_ITERATIONS;

  logic signed [33:0] x_r, y_r, z_r;
  logic [4:0] i_r;
  logic busy_r, flip_r, done_r;
  logic signed [33:0] zm, zr, zf;
  logic fold;
  logic signed [33:0] xs, ys, sr, cr;
  logic signed [15:0] sc, cc;

  always_comb begin
    // pitch and yaw never leave one turn, so a single compare-subtract
    // gives the truncated remainder by 360
    zm = 34'(req.angle);
    if (zm >= DEG360) zm = zm - DEG360;
    else if (zm <= -DEG360) zm = zm + DEG360;
    zr = zm;
    if (zm > DEG180) zr = zm - DEG360;
    else if (zm < -DEG180) zr = zm + DEG360;
    zf = zr;
    fold = 1'b0;
    if (zr > DEG90) begin zf = zr - DEG180; fold = 1'b1; end
    else if (zr < -DEG90) begin zf = zr + DEG180; fold = 1'b1; end
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    sr = (y_r + 34'sd32768) >>> 16;
    cr = (x_r + 34'sd32768) >>> 16;
    sc = (sr > 34'sd16384) ? ONE_Q14 : (sr < -34'sd16384) ? -ONE_Q14 : sr[15:0];
    cc = (cr > 34'sd16384) ? ONE_Q14 : (cr < -34'sd16384) ? -ONE_Q14 : cr[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !req.start && busy_r && (32'(i_r) == N);
      if (req.start) begin
        busy_r <= 1'b1;
        i_r <= '0;
        x_r <= CORDIC_K;
        y_r <= '0;
        flip_r <= fold;
        z_r <= zf;
      end else if (busy_r) begin
        if (32'(i_r) == N) begin
          busy_r <= 1'b0;
        end else begin
          if (!z_r[33]) begin
            x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - 34'(atan_q16(i_r));
          end else begin
            x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + 34'(atan_q16(i_r));
          end
          i_r <= i_r + 5'd1;
        end
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.sin_v = flip_r ? -sc : sc;
  assign rsp.cos_v = flip_r ? -cc : cc;
endmodule

// ----- rtl/core/fpcv_checker.sv -----
`timescale 1ns / 1ps
module fpcv_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] row_index,
  input logic last_row
);
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken while rows pending");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (last_row == (row_index == 2'd3))) else $error("last_row wrong");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !last_row) |=> (out_valid && row_index == $past(row_index) + 2'd1))
    else $error("row sequence broken");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(row_index))) else $error("row dropped");
endmodule

bind first_person_camera_view_core fpcv_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .row_index(out_ch.data.row_index), .last_row(out_ch.data.last_row));

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import fpcv_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  fpcv_stream_if #(.payload_t(in_item_t))  in_ch ();
  fpcv_stream_if #(.payload_t(out_item_t)) out_ch ();

  first_person_camera_view_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Camera shadow state, updated on every accepted item
  longint cam_pitch, cam_yaw;
  longint cam_pos [3];
  longint cam_front [3];
  longint cam_right [3];
  longint speed_reg, sens_reg;

  in_item_t  pend_q [$];   // items waiting to be offered
  out_item_t rows_q [$];   // matrix rows still to arrive
  int        errors;
  int        gap_left, stall_left, hold_left;
  int        draw;
  bit        burst_mode;   // sender side: no gaps while set
  bit        steady_mode;  // receiver side: no stalls while set

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Limit: far beyond the slowest legal run
  initial begin
    #2400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------- arithmetic helpers ----------------
  // Rounding right shift: add half an LSB, then shift arithmetically
  function automatic longint rnd_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clip_unit(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  // Rotation-mode CORDIC on an angle in Q16 degrees
  task automatic trig_q14(input longint angle, output longint s_o, output longint c_o);
    longint z, x, y, nx, s, c;
    bit flip;
    z = angle % longint'(DEG360);
    x = longint'(CORDIC_K);
    y = 0;
    flip = 1'b0;
    if (z > longint'(DEG180)) z -= longint'(DEG360);
    else if (z < -longint'(DEG180)) z += longint'(DEG360);
    // beyond a right angle: fold by half a turn and negate both results
    if (z > longint'(DEG90)) begin
      z -= longint'(DEG180);
      flip = 1'b1;
    end else if (z < -longint'(DEG90)) begin
      z += longint'(DEG180);
      flip = 1'b1;
    end
    for (int i = 0; i < TRIG_ITERATIONS_DEF && i < ATAN_ENTRIES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= longint'(atan_q16(i[4:0]));
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += longint'(atan_q16(i[4:0]));
      end
      x = nx;
    end
    s = clip_unit(rnd_shift(y, 16));
    c = clip_unit(rnd_shift(x, 16));
    s_o = flip ? -s : s;
    c_o = flip ? -c : c;
  endtask

  function automatic longint dot_with_pos(longint a0, longint a1, longint a2);
    return clip32(rnd_shift(a0 * cam_pos[0] + a1 * cam_pos[1] + a2 * cam_pos[2], 14));
  endfunction

  // Apply one accepted item to the shadow camera; view items queue four rows
  task automatic camera_step(input in_item_t it);
    longint d, p, yw, sy, cy, sp, cp;
    longint f [3];
    longint r [3];
    longint u [3];
    longint cols [4][4];
    out_item_t row;
    case (it.req_type)
      REQ_MOVE: begin
        if (it.move_dir <= DIR_RIGHT) begin
          for (int k = 0; k < 3; k++) begin
            d = rnd_shift(((it.move_dir < DIR_LEFT) ? cam_front[k] : cam_right[k]) *
                          speed_reg * longint'(it.frame_time), 22);
            if (it.move_dir == DIR_BACK || it.move_dir == DIR_LEFT) d = -d;
            cam_pos[k] = clip32(cam_pos[k] + d);
          end
        end
      end
      REQ_LOOK: begin
        p  = clip32(cam_pitch + rnd_shift(longint'(it.offset_vert) * sens_reg *
                                          longint'(it.frame_time), 12));
        yw = clip32(cam_yaw + rnd_shift(longint'(it.offset_horiz) * sens_reg *
                                        longint'(it.frame_time), 12));
        if (p > longint'(DEG80)) p = longint'(DEG80);
        else if (p < -longint'(DEG80)) p = -longint'(DEG80);
        if (yw > longint'(DEG360) || yw < -longint'(DEG360)) yw = 0;
        cam_pitch = p;
        cam_yaw   = yw;
      end
      REQ_SETP: begin
        cam_pos[0] = longint'(it.new_x);
        cam_pos[1] = longint'(it.new_y);
        cam_pos[2] = longint'(it.new_z);
      end
      default: begin
        trig_q14(cam_yaw, sy, cy);
        trig_q14(cam_pitch, sp, cp);
        f[0] = rnd_shift(cy * cp, 14);
        f[1] = sp;
        f[2] = rnd_shift(sy * cp, 14);
        r[0] = -sy;
        r[1] = 0;
        r[2] = cy;
        u[0] = -rnd_shift(cy * sp, 14);
        u[1] = cp;
        u[2] = -rnd_shift(sy * sp, 14);
        for (int k = 0; k < 3; k++) begin
          cam_front[k] = f[k];
          cam_right[k] = r[k];
          cols[0][k] = rnd_shift(r[k] <<< 16, 14);
          cols[1][k] = rnd_shift(u[k] <<< 16, 14);
          cols[2][k] = rnd_shift((-f[k]) <<< 16, 14);
          cols[3][k] = 0;
        end
        // translation column saturates
        cols[0][3] = clip32(-dot_with_pos(r[0], r[1], r[2]));
        cols[1][3] = clip32(-dot_with_pos(u[0], u[1], u[2]));
        cols[2][3] = dot_with_pos(f[0], f[1], f[2]);
        cols[3][3] = 65536;
        for (int rw = 0; rw < 4; rw++) begin
          row.row_index = rw[1:0];
          row.col0 = cols[rw][0][31:0];
          row.col1 = cols[rw][1][31:0];
          row.col2 = cols[rw][2][31:0];
          row.col3 = cols[rw][3][31:0];
          row.cam_x = cam_pos[0][31:0];
          row.cam_y = cam_pos[1][31:0];
          row.cam_z = cam_pos[2][31:0];
          row.last_row = (rw == 3);
          rows_q.push_back(row);
        end
      end
    endcase
  endtask

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_row(input out_item_t got);
    out_item_t want;
    if (rows_q.size() == 0) begin
      report("unexpected row, row_index", got.row_index, -1);
      return;
    end
    want = rows_q.pop_front();
    if (got.row_index !== want.row_index) report("row_index", got.row_index, want.row_index);
    if (got.col0 !== want.col0) report("col0", got.col0, want.col0);
    if (got.col1 !== want.col1) report("col1", got.col1, want.col1);
    if (got.col2 !== want.col2) report("col2", got.col2, want.col2);
    if (got.col3 !== want.col3) report("col3", got.col3, want.col3);
    if (got.cam_x !== want.cam_x) report("cam_x", got.cam_x, want.cam_x);
    if (got.cam_y !== want.cam_y) report("cam_y", got.cam_y, want.cam_y);
    if (got.cam_z !== want.cam_z) report("cam_z", got.cam_z, want.cam_z);
    if (got.last_row !== want.last_row) report("last_row", got.last_row, want.last_row);
  endtask

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) camera_step(in_ch.data);
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left    <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          in_ch.data  <= pend_q.pop_front();
          in_ch.valid <= 1'b1;
          gap_left    <= burst_mode ? 0 : $urandom_range(0, 13);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_row(out_ch.data);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
      end else if (out_ch.valid && out_ch.ready) begin
        // new stall drawn after every row
        draw = steady_mode ? 0 : $urandom_range(0, 13);
        stall_left   <= (draw > 0) ? draw - 1 : 0;
        out_ch.ready <= (draw == 0);
      end else if (stall_left > 0) begin
        stall_left   <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off, counted down here
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // ---------------- stimulus ----------------
  function automatic in_item_t mk_item(logic [1:0] req, logic [15:0] dt, logic [2:0] dir,
                                       logic [15:0] oh, logic [15:0] ov,
                                       logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_item_t it;
    it.req_type = req;
    it.frame_time = dt;
    it.move_dir = dir;
    it.offset_horiz = oh;
    it.offset_vert = ov;
    it.new_x = x;
    it.new_y = y;
    it.new_z = z;
    return it;
  endfunction

  // random content everywhere, so every field bit toggles regardless of kind
  function automatic in_item_t rand_item();
    in_item_t it;
    int pick;
    it = mk_item(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                 3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom),
                 $urandom, $urandom, $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) it.req_type = REQ_VIEW;
    else if (pick < 62) it.req_type = REQ_MOVE;
    else if (pick < 84) it.req_type = REQ_LOOK;
    else it.req_type = REQ_SETP;
    // mostly modest positions so translations stay meaningful
    if (it.req_type == REQ_SETP && $urandom_range(0, 3) != 0) begin
      it.new_x = $signed($urandom_range(0, 2000000)) - 1000000;
      it.new_y = $signed($urandom_range(0, 2000000)) - 1000000;
      it.new_z = $signed($urandom_range(0, 2000000)) - 1000000;
    end
    if (it.req_type == REQ_LOOK && $urandom_range(0, 2) != 0) begin
      it.offset_horiz = 16'($signed($urandom_range(0, 800)) - 400);
      it.offset_vert  = 16'($signed($urandom_range(0, 800)) - 400);
    end
    if (it.req_type == REQ_MOVE && $urandom_range(0, 3) != 0)
      it.move_dir = 3'($urandom_range(0, 3));
    return it;
  endfunction

  task automatic cfg_write(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_SPEED) speed_reg = val;
    else sens_reg = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until all offered items are taken and all rows are in, then let
  // any trailing non-view item finish
  task automatic drain();
    do @(negedge clk); while (pend_q.size() != 0 || in_ch.valid || rows_q.size() != 0);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    errors = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_SPEED;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    hold_left = 0;
    burst_mode = 1'b0;
    steady_mode = 1'b0;
    speed_reg = 1280;
    sens_reg = 1280;
    cam_pitch = 0;
    cam_yaw = longint'(DEG90);
    cam_pos = '{0, 0, 0};
    cam_front = '{0, 0, 16384};
    cam_right = '{-16384, 0, 0};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: default vectors, every direction incl. unknown ones, extremes
    pend_q.push_back(mk_item(REQ_MOVE, 16'hFFFF, DIR_FWD, 0, 0, 0, 0, 0));
    pend_q.push_back(mk_item(REQ_VIEW, 0, 0, 0, 0, 0, 0, 0));
    for (int d = 0; d < 8; d++)
      pend_q.push_back(mk_item(REQ_MOVE, 16'hFFFF, 3'(d), 0, 0, 0, 0, 0));
    pend_q.push_back(mk_item(REQ_VIEW, 0, 0, 0, 0, 0, 0, 0));
    pend_q.push_back(mk_item(REQ_LOOK, 16'hFFFF, 0, 16'sh7FFF, 16'sh7FFF, 0, 0, 0));
    pend_q.push_back(mk_item(REQ_VIEW, 0, 0, 0, 0, 0, 0, 0));
    pend_q.push_back(mk_item(REQ_LOOK, 16'hFFFF, 0, 16'sh8000, 16'sh8000, 0, 0, 0));
    pend_q.push_back(mk_item(REQ_VIEW, 0, 0, 0, 0, 0, 0, 0));
    // translation overflow at the position extremes
    pend_q.push_back(mk_item(REQ_SETP, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
    pend_q.push_back(mk_item(REQ_VIEW, 0, 0, 0, 0, 0, 0, 0));
    pend_q.push_back(mk_item(REQ_MOVE, 16'hFFFF, DIR_FWD, 0, 0, 0, 0, 0));
    pend_q.push_back(mk_item(REQ_SETP, 0, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000));
    pend_q.push_back(mk_item(REQ_VIEW, 0, 0, 0, 0, 0, 0, 0));
    pend_q.push_back(mk_item(REQ_MOVE, 16'hFFFF, DIR_BACK, 0, 0, 0, 0, 0));
    pend_q.push_back(mk_item(REQ_VIEW, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // saturated registers, gapless sender
    cfg_write(CFG_SPEED, 16'hFFFF);
    cfg_write(CFG_SENS, 16'hFFFF);
    burst_mode = 1'b1;
    for (int i = 0; i < 50; i++) pend_q.push_back(rand_item());
    drain();

    // zero registers; receiver holds off while views pile up behind it
    cfg_write(CFG_SPEED, 16'h0000);
    cfg_write(CFG_SENS, 16'h0000);
    burst_mode = 1'b0;
    @(negedge clk);
    hold_left = 700;
    for (int i = 0; i < 20; i++)
      pend_q.push_back(mk_item(REQ_VIEW, 16'($urandom), 3'($urandom), 16'($urandom),
                               16'($urandom), $urandom, $urandom, $urandom));
    for (int i = 0; i < 20; i++) pend_q.push_back(rand_item());
    drain();

    // random register values, alternating idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      cfg_write(CFG_SPEED, 16'($urandom));
      cfg_write(CFG_SENS, (ph == 3) ? 16'd1280 : 16'($urandom_range(0, 4000)));
      burst_mode = ph[0];
      steady_mode = (ph == 2);
      for (int i = 0; i < 30; i++) pend_q.push_back(rand_item());
      drain();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/fpcv_pkg.sv
rtl/core/fpcv_stream_if.sv
rtl/core/fpcv_cordic.sv
rtl/core/first_person_camera_view_core.sv
rtl/core/fpcv_checker.sv
verif/tb.sv
